/* src/periodic_job_timer_table_unit_defines.svh */
// ---------------------------------------------------------------------------
// Periodic job timer table: assertion macros
// Shared assertion forms used by the port checker.
// ---------------------------------------------------------------------------
`ifndef PERIODIC_JOB_TIMER_TABLE_UNIT_DEFINES_SVH
`define PERIODIC_JOB_TIMER_TABLE_UNIT_DEFINES_SVH

// Same-cycle implication, sampled on clk and disabled while rst_n is low.
`define PJT_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk and disabled while rst_n is low.
`define PJT_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* src/pjt_pkg.sv */
// ---------------------------------------------------------------------------
// Periodic job timer table: package
// Sizes, operation codes, control structs and helper functions.
// ---------------------------------------------------------------------------
`default_nettype none

package pjt_pkg;

  // Table size and derived index width.
  localparam int unsigned NUM_SLOTS = 16;
  localparam int unsigned IDX_W     = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;

  // Fixed field widths.
  localparam int unsigned OP_W   = 2;
  localparam int unsigned SLOT_W = 4;
  localparam int unsigned TIME_W = 32;

  // Operation codes.
  localparam logic [OP_W-1:0] OP_REGISTER   = 2'd0;
  localparam logic [OP_W-1:0] OP_UNREGISTER = 2'd1;
  localparam logic [OP_W-1:0] OP_TICK       = 2'd2;

  typedef logic [IDX_W-1:0]     idx_t;
  typedef logic [NUM_SLOTS-1:0] mask_t;
  typedef logic [TIME_W-1:0]    time_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accept;
    logic rd_en;
    logic cmp_en;
    logic emit_en;
    idx_t idx;
    idx_t cmp_idx;
  } pjt_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic mask_empty;
    logic cur_due;
    logic cur_last;
    logic out_free;
  } pjt_stat_t;

  // Saturating time sum.
  function automatic time_t sat_add(input time_t a, input time_t b);
    logic [TIME_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[TIME_W] ? '1 : s[TIME_W-1:0];
  endfunction

  // Slot field to table index.
  function automatic idx_t slot_to_idx(input logic [SLOT_W-1:0] slot);
    logic [IDX_W+SLOT_W-1:0] ext;
    ext = {{IDX_W{1'b0}}, slot};
    return ext[IDX_W-1:0];
  endfunction

  // Table index to slot field.
  function automatic logic [SLOT_W-1:0] idx_to_slot(input idx_t idx);
    logic [IDX_W+SLOT_W-1:0] ext;
    ext = {{SLOT_W{1'b0}}, idx};
    return ext[SLOT_W-1:0];
  endfunction

endpackage

`default_nettype wire

/* src/pjt_intf.sv */
// ---------------------------------------------------------------------------
// Periodic job timer table: channel interfaces
// Valid/ready channels for timer items and due-slot results.
// ---------------------------------------------------------------------------
`default_nettype none

// Input channel: one timer item per transfer.
interface pjt_in_if;
  logic                        valid;
  logic                        ready;
  logic [pjt_pkg::OP_W-1:0]    op;
  logic [pjt_pkg::SLOT_W-1:0]  slot;
  logic [pjt_pkg::TIME_W-1:0]  interval;
  logic [pjt_pkg::TIME_W-1:0]  now;

  modport source (output valid, op, slot, interval, now, input ready);
  modport sink   (input valid, op, slot, interval, now, output ready);
endinterface

// Result channel: one due slot per transfer.
interface pjt_out_if;
  logic                        valid;
  logic                        ready;
  logic [pjt_pkg::SLOT_W-1:0]  due_slot;
  logic                        last;

  modport source (output valid, due_slot, last, input ready);
  modport sink   (input valid, due_slot, last, output ready);
endinterface

`default_nettype wire

/* src/pjt_ctrl.sv */
// ---------------------------------------------------------------------------
// Periodic job timer table: controller
// Sequences the slot scan of a tick and the emission of due slots.
// ---------------------------------------------------------------------------
`default_nettype none

module pjt_ctrl (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     in_valid,
  input  wire logic [pjt_pkg::OP_W-1:0] in_op,
  input  wire pjt_pkg::pjt_stat_t       stat,
  output logic                          in_ready,
  output pjt_pkg::pjt_cmd_t             cmd
);

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_SCAN  = 4'b0010,
    ST_DRAIN = 4'b0100,
    ST_EMIT  = 4'b1000
  } state_t;

  localparam pjt_pkg::idx_t IDX_LAST = pjt_pkg::IDX_W'(pjt_pkg::NUM_SLOTS - 1);

  state_t         state_r, state_nxt;
  pjt_pkg::idx_t  idx_r, idx_nxt;
  logic           cmp_vld_r;
  pjt_pkg::idx_t  cmp_idx_r;
  logic           accept;

  // The input stays closed while reset is held.
  assign in_ready = rst_n && (state_r == ST_IDLE);
  assign accept   = in_valid && in_ready;

  // Next state, slot counter and commands.
  always_comb begin
    state_nxt   = state_r;
    idx_nxt     = idx_r;
    cmd.accept  = accept;
    cmd.rd_en   = 1'b0;
    cmd.cmp_en  = cmp_vld_r;
    cmd.emit_en = 1'b0;
    cmd.idx     = idx_r;
    cmd.cmp_idx = cmp_idx_r;
    unique case (state_r)
      ST_IDLE: begin
        idx_nxt = '0;
        if (accept && (in_op == pjt_pkg::OP_TICK)) begin
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        cmd.rd_en = 1'b1;
        if (idx_r == IDX_LAST) begin
          state_nxt = ST_DRAIN;
          idx_nxt   = '0;
        end else begin
          idx_nxt = idx_r + pjt_pkg::IDX_W'(1);
        end
      end
      ST_DRAIN: begin
        // The last slot is compared in this cycle.
        state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        if (stat.mask_empty) begin
          state_nxt = ST_IDLE;
        end else if (stat.cur_due) begin
          if (stat.out_free) begin
            cmd.emit_en = 1'b1;
            if (stat.cur_last) begin
              state_nxt = ST_IDLE;
            end else begin
              idx_nxt = idx_r + pjt_pkg::IDX_W'(1);
            end
          end
        end else begin
          idx_nxt = idx_r + pjt_pkg::IDX_W'(1);
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      idx_r     <= '0;
      cmp_vld_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      idx_r     <= idx_nxt;
      cmp_vld_r <= cmd.rd_en;
    end
  end

  // Index of the slot whose read data arrives next cycle.
  always_ff @(posedge clk) begin
    cmp_idx_r <= idx_r;
  end

endmodule

`default_nettype wire

/* src/pjt_dpath.sv */
// ---------------------------------------------------------------------------
// Periodic job timer table: datapath
// Slot tables, deadline compare and update, due mask and result register.
// ---------------------------------------------------------------------------
`default_nettype none

module pjt_dpath (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire pjt_pkg::pjt_cmd_t          cmd,
  input  wire logic [pjt_pkg::OP_W-1:0]   in_op,
  input  wire logic [pjt_pkg::SLOT_W-1:0] in_slot,
  input  wire pjt_pkg::time_t             in_interval,
  input  wire pjt_pkg::time_t             in_now,
  input  wire logic                       out_ready,
  output pjt_pkg::pjt_stat_t              stat,
  output logic                            out_valid,
  output logic [pjt_pkg::SLOT_W-1:0]      out_due_slot,
  output logic                            out_last
);

  pjt_pkg::time_t  deadline_mem [pjt_pkg::NUM_SLOTS];
  pjt_pkg::time_t  period_mem   [pjt_pkg::NUM_SLOTS];

  pjt_pkg::mask_t  armed_r, armed_nxt;
  pjt_pkg::mask_t  mask_r, mask_nxt;
  pjt_pkg::time_t  now_r;
  pjt_pkg::time_t  dl_q_r;
  pjt_pkg::time_t  pd_q_r;
  logic            out_valid_r;
  logic [pjt_pkg::SLOT_W-1:0] due_slot_r;
  logic            last_r;

  pjt_pkg::idx_t   in_idx;
  logic            slot_ok;
  logic            do_reg;
  logic            do_unreg;
  logic            do_tick;
  logic            due;
  pjt_pkg::mask_t  cur_bit;

  logic            wr_en;
  pjt_pkg::idx_t   wr_idx;
  pjt_pkg::time_t  wr_deadline;

  // Decode of an accepted item.
  assign in_idx   = pjt_pkg::slot_to_idx(in_slot);
  assign slot_ok  = ({28'd0, in_slot} < 32'(pjt_pkg::NUM_SLOTS));
  assign do_reg   = cmd.accept && (in_op == pjt_pkg::OP_REGISTER) && slot_ok
                    && !armed_r[in_idx];
  assign do_unreg = cmd.accept && (in_op == pjt_pkg::OP_UNREGISTER) && slot_ok;
  assign do_tick  = cmd.accept && (in_op == pjt_pkg::OP_TICK);

  // A scanned slot is due when armed and its deadline has passed.
  assign due = cmd.cmp_en && armed_r[cmd.cmp_idx] && (now_r >= dl_q_r);

  // Deadline write port, shared by arming and by scan write-back.
  always_comb begin
    wr_en       = do_reg || due;
    wr_idx      = cmd.cmp_idx;
    wr_deadline = pjt_pkg::sat_add(now_r, pd_q_r);
    if (do_reg) begin
      wr_idx      = in_idx;
      wr_deadline = pjt_pkg::sat_add(in_now, in_interval);
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      deadline_mem[wr_idx] <= wr_deadline;
    end
  end

  always_ff @(posedge clk) begin
    if (do_reg) begin
      period_mem[in_idx] <= in_interval;
    end
  end

  // Registered table reads for the scan.
  always_ff @(posedge clk) begin
    if (cmd.rd_en) begin
      dl_q_r <= deadline_mem[cmd.idx];
      pd_q_r <= period_mem[cmd.idx];
    end
  end

  // Tick time held for the whole scan.
  always_ff @(posedge clk) begin
    if (do_tick) begin
      now_r <= in_now;
    end
  end

  // Armed bits and the due mask of the current tick.
  assign cur_bit = pjt_pkg::mask_t'(1) << cmd.idx;

  always_comb begin
    armed_nxt = armed_r;
    if (do_reg) begin
      armed_nxt[in_idx] = 1'b1;
    end
    if (do_unreg) begin
      armed_nxt[in_idx] = 1'b0;
    end
  end

  always_comb begin
    mask_nxt = mask_r;
    if (do_tick) begin
      mask_nxt = '0;
    end
    if (due) begin
      mask_nxt[cmd.cmp_idx] = 1'b1;
    end
    if (cmd.emit_en) begin
      mask_nxt = mask_r & ~cur_bit;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      armed_r <= '0;
      mask_r  <= '0;
    end else begin
      armed_r <= armed_nxt;
      mask_r  <= mask_nxt;
    end
  end

  // Emission status. Lower mask bits are already cleared while emitting.
  assign stat.mask_empty = (mask_r == '0);
  assign stat.cur_due    = mask_r[cmd.idx];
  assign stat.cur_last   = ((mask_r & ~cur_bit) == '0);
  assign stat.out_free   = !out_valid_r || out_ready;

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit_en) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_en) begin
      due_slot_r <= pjt_pkg::idx_to_slot(cmd.idx);
      last_r     <= stat.cur_last;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_due_slot = due_slot_r;
  assign out_last     = last_r;

endmodule

`default_nettype wire

/* src/periodic_job_timer_table_unit.sv */
// ---------------------------------------------------------------------------
// Periodic job timer table unit
// Table of periodic timer slots that reports due slots on every time tick.
// ---------------------------------------------------------------------------
// Usage:
// Items arrive on in_if (op, slot, interval, now) and are taken on a transfer.
// A register item arms a free slot with deadline now + interval (saturating);
// an unregister item frees a slot. Neither gives a result;
// in_if.ready stays high for the next item.
// A tick item starts a scan of the table, one slot per cycle through the
// registered table read port, then a final compare of the last slot.
// Due slots then leave on out_if in ascending order, one slot index per
// cycle walked while the result register is free, last set on the final one.
// in_if.ready is low from a tick transfer until the last result is loaded,
// or until the due mask is found empty.
// A result register parts the two sides; when out_if.ready is low, the
// emission waits on the held result and resumes once it is taken.
// Synchronous reset disarms every slot and empties the result register;
// slot tables need no clearing since only armed slots can be due.
// ---------------------------------------------------------------------------
`default_nettype none

module periodic_job_timer_table_unit (
  input  wire logic  clk,
  input  wire logic  rst_n,
  pjt_in_if.sink     in_if,
  pjt_out_if.source  out_if
);

  pjt_pkg::pjt_cmd_t  cmd;
  pjt_pkg::pjt_stat_t stat;
  logic               in_ready;

  assign in_if.ready = in_ready;

  // Sequencer.
  pjt_ctrl u_pjt_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_if.valid),
    .in_op    (in_if.op),
    .stat     (stat),
    .in_ready (in_ready),
    .cmd      (cmd)
  );

  // Slot tables and result register.
  pjt_dpath u_pjt_dpath (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .in_op        (in_if.op),
    .in_slot      (in_if.slot),
    .in_interval  (in_if.interval),
    .in_now       (in_if.now),
    .out_ready    (out_if.ready),
    .stat         (stat),
    .out_valid    (out_if.valid),
    .out_due_slot (out_if.due_slot),
    .out_last     (out_if.last)
  );

endmodule

`default_nettype wire

/* src/pjt_checker.sv */
// ---------------------------------------------------------------------------
// Periodic job timer table: port checker
// Checks handshake behavior seen at the top-level ports.
// ---------------------------------------------------------------------------
`default_nettype none

`include "periodic_job_timer_table_unit_defines.svh"

module pjt_checker (
  input wire logic                       clk,
  input wire logic                       rst_n,
  input wire logic                       in_valid,
  input wire logic                       in_ready,
  input wire logic [pjt_pkg::OP_W-1:0]   in_op,
  input wire logic                       out_valid,
  input wire logic                       out_ready,
  input wire logic [pjt_pkg::SLOT_W-1:0] out_due_slot,
  input wire logic                       out_last
);

  logic in_xfer;
  logic tick_xfer;
  logic cmd_xfer;
  logic out_stall;
  logic [pjt_pkg::SLOT_W:0] out_bits;

  assign in_xfer   = in_valid && in_ready;
  assign tick_xfer = in_xfer && (in_op == pjt_pkg::OP_TICK);
  assign cmd_xfer  = in_xfer && !(in_op == pjt_pkg::OP_TICK);
  assign out_stall = out_valid && !out_ready;
  assign out_bits  = {out_due_slot, out_last};

  // A stalled result holds its contents.
  `PJT_ASSERT_NEXT(a_out_hold, out_stall, out_valid && $stable(out_bits), "held result changed")

  // A tick transfer closes the input until its scan and emission are done.
  `PJT_ASSERT_NEXT(a_tick_busy, tick_xfer, !in_ready, "input open right after a tick")

  // Register and unregister items leave the input open.
  `PJT_ASSERT_NEXT(a_cmd_open, cmd_xfer, in_ready, "input closed after a non-tick item")

  // A new result only comes from tick emission, while the input is closed.
  `PJT_ASSERT_NOW(a_out_source, $rose(out_valid), !$past(in_ready), "result outside emission")

endmodule

bind periodic_job_timer_table_unit pjt_checker u_pjt_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_valid     (in_if.valid),
  .in_ready     (in_if.ready),
  .in_op        (in_if.op),
  .out_valid    (out_if.valid),
  .out_ready    (out_if.ready),
  .out_due_slot (out_if.due_slot),
  .out_last     (out_if.last)
);

`default_nettype wire
